### sv/clns_pkg.sv
// ----------------------------------------------------------------------------
// Character LCD nibble sequencer package
// Transfer types, request codes and the instruction constants that the
// sequencer builds its pin-state runs from.
// ----------------------------------------------------------------------------
package clns_pkg;

   typedef struct packed {
      logic [3:0] req_type;
      logic       flag_a;
      logic       flag_b;
      logic       flag_c;
      logic [6:0] ram_address;
      logic [7:0] char_code;
   } clns_req_type;

   typedef struct packed {
      logic       reg_select;
      logic       enable;
      logic [3:0] nibble;
      logic [6:0] wait_ms;
      logic       last;
   } clns_rsp_type;

   localparam logic [3:0] REQ_INIT          = 4'd0;
   localparam logic [3:0] REQ_RESET         = 4'd1;
   localparam logic [3:0] REQ_FUNCTION_SET  = 4'd2;
   localparam logic [3:0] REQ_ENTRY_MODE    = 4'd3;
   localparam logic [3:0] REQ_CLEAR         = 4'd4;
   localparam logic [3:0] REQ_DISPLAY_CTRL  = 4'd5;
   localparam logic [3:0] REQ_CURSOR_SHIFT  = 4'd6;
   localparam logic [3:0] REQ_DISPLAY_SHIFT = 4'd7;
   localparam logic [3:0] REQ_HOME          = 4'd8;
   localparam logic [3:0] REQ_CGRAM_ADDR    = 4'd9;
   localparam logic [3:0] REQ_DDRAM_ADDR    = 4'd10;
   localparam logic [3:0] REQ_LINE_SELECT   = 4'd11;
   localparam logic [3:0] REQ_WRITE_CHAR    = 4'd12;

   localparam logic [7:0] CMD_FUNCTION_SET  = 8'b0010_0000;
   localparam logic [7:0] CMD_ENTRY_MODE    = 8'b0000_0100;
   localparam logic [7:0] CMD_CLEAR         = 8'b0000_0001;
   localparam logic [7:0] CMD_CURSOR_SHIFT  = 8'b0001_0000;
   localparam logic [7:0] CMD_DISPLAY_SHIFT = 8'b0001_1000;
   localparam logic [7:0] CMD_HOME          = 8'b0000_0010;
   localparam logic [7:0] CMD_CGRAM_ADDR    = 8'b0100_0000;
   localparam logic [7:0] CMD_DDRAM_ADDR    = 8'b1000_0000;
   localparam logic [7:0] CMD_DISPLAY_CTRL  = 8'b0000_1000;
   localparam logic [7:0] LINE_TWO_ADDR     = 8'h40;

   localparam logic [3:0] NIBBLE_WAKE       = 4'b0011;
   localparam logic [3:0] NIBBLE_FOUR_BIT   = 4'b0010;

   localparam logic [6:0] WAIT_PULSE        = 7'd5;
   localparam logic [6:0] WAIT_POWER_UP     = 7'd100;
   localparam logic [6:0] WAIT_WAKE         = 7'd1;
   localparam logic [6:0] WAIT_NONE         = 7'd0;

   localparam logic [1:0] KIND_BYTE         = 2'd0;
   localparam logic [1:0] KIND_RESET        = 2'd1;
   localparam logic [1:0] KIND_INIT         = 2'd2;

   localparam logic [4:0] LAST_STEP_BYTE    = 5'd3;
   localparam logic [4:0] LAST_STEP_RESET   = 5'd8;
   localparam logic [4:0] LAST_STEP_INIT    = 5'd26;
   localparam logic [4:0] INIT_RESET_START  = 5'd2;
   localparam logic [4:0] INIT_BYTES_START  = 5'd11;

   localparam logic [7:0] INIT_BYTES [4] = '{8'h28, 8'h01, 8'h0F, 8'h06};

endpackage

### sv/char_lcd_nibble_command_sequencer_top.sv
// ----------------------------------------------------------------------------
// Character LCD nibble command sequencer
// Turns LCD requests into runs of register-select, enable, nibble and
// hold-time pin states for a character LCD on a 4-bit data bus.
// ----------------------------------------------------------------------------
// One pin state leaves the output register per cycle while the result side
// takes transfers. A run is 4 pin states for an instruction or character
// byte, 9 for the reset run and 27 for the init run, as a single step counter
// walks the run. The next request is taken in the cycle the final state of
// the current run enters the output register. A request of an unknown type
// is taken and gives no result.
module char_lcd_nibble_command_sequencer_top (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  clns_pkg::clns_req_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output clns_pkg::clns_rsp_type rsp_data
);

   logic                   busy_ff, busy_in;
   logic [1:0]             kind_ff, kind_in;
   logic [4:0]             step_ff, step_in;
   logic [7:0]             byte_ff, byte_in;
   logic                   rs_ff, rs_in;
   logic                   rs_lvl_ff, rs_lvl_in;
   logic                   en_lvl_ff, en_lvl_in;
   logic [3:0]             nib_lvl_ff, nib_lvl_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   clns_pkg::clns_rsp_type rsp_data_ff, rsp_data_in;

   clns_pkg::clns_rsp_type gen;
   logic                   advance;
   logic                   finishing;
   logic                   req_accept;
   logic                   req_known;
   logic [1:0]             req_kind;
   logic [7:0]             req_byte;
   logic                   req_rs;
   logic [4:0]             reset_pos;
   logic [2:0]             wake_pos;
   logic [4:0]             byte_pos;
   logic [7:0]             cur_byte;
   logic                   cur_rs;
   logic                   in_reset_phase;
   logic                   in_pulse_phase;

   // Request decode into the instruction or data byte.
   always_comb begin
      req_known = 1'b1;
      req_kind  = clns_pkg::KIND_BYTE;
      req_byte  = 8'h00;
      req_rs    = 1'b0;
      case (req_data.req_type)
         clns_pkg::REQ_INIT: begin
            req_kind = clns_pkg::KIND_INIT;
         end
         clns_pkg::REQ_RESET: begin
            req_kind = clns_pkg::KIND_RESET;
         end
         clns_pkg::REQ_FUNCTION_SET: begin
            req_byte = clns_pkg::CMD_FUNCTION_SET
                     | {3'b000, req_data.flag_a, req_data.flag_b, req_data.flag_c, 2'b00};
         end
         clns_pkg::REQ_ENTRY_MODE: begin
            req_byte = clns_pkg::CMD_ENTRY_MODE
                     | {6'b000000, req_data.flag_a, req_data.flag_b};
         end
         clns_pkg::REQ_CLEAR: begin
            req_byte = clns_pkg::CMD_CLEAR;
         end
         clns_pkg::REQ_DISPLAY_CTRL: begin
            req_byte = clns_pkg::CMD_DISPLAY_CTRL
                     | {5'b00000, req_data.flag_a, req_data.flag_b, req_data.flag_c};
         end
         clns_pkg::REQ_CURSOR_SHIFT: begin
            req_byte = clns_pkg::CMD_CURSOR_SHIFT | {5'b00000, req_data.flag_a, 2'b00};
         end
         clns_pkg::REQ_DISPLAY_SHIFT: begin
            req_byte = clns_pkg::CMD_DISPLAY_SHIFT | {5'b00000, req_data.flag_a, 2'b00};
         end
         clns_pkg::REQ_HOME: begin
            req_byte = clns_pkg::CMD_HOME;
         end
         clns_pkg::REQ_CGRAM_ADDR: begin
            req_byte = clns_pkg::CMD_CGRAM_ADDR | {2'b00, req_data.ram_address[5:0]};
         end
         clns_pkg::REQ_DDRAM_ADDR: begin
            req_byte = clns_pkg::CMD_DDRAM_ADDR | {1'b0, req_data.ram_address};
         end
         clns_pkg::REQ_LINE_SELECT: begin
            req_byte = req_data.flag_a ? (clns_pkg::CMD_DDRAM_ADDR | clns_pkg::LINE_TWO_ADDR)
                                       : clns_pkg::CMD_DDRAM_ADDR;
         end
         clns_pkg::REQ_WRITE_CHAR: begin
            req_byte = req_data.char_code;
            req_rs   = 1'b1;
         end
         default: begin
            req_known = 1'b0;
         end
      endcase
   end

   // Pin state for the current step of the run.
   always_comb begin
      in_pulse_phase = (kind_ff == clns_pkg::KIND_INIT) && (step_ff < clns_pkg::INIT_RESET_START);
      in_reset_phase = (kind_ff == clns_pkg::KIND_RESET)
                    || ((kind_ff == clns_pkg::KIND_INIT) && !in_pulse_phase
                        && (step_ff < clns_pkg::INIT_BYTES_START));
      reset_pos = (kind_ff == clns_pkg::KIND_INIT) ? step_ff - clns_pkg::INIT_RESET_START
                                                    : step_ff;
      wake_pos  = 3'(reset_pos - 5'd1);
      byte_pos  = (kind_ff == clns_pkg::KIND_INIT) ? step_ff - clns_pkg::INIT_BYTES_START
                                                    : step_ff;
      cur_byte  = (kind_ff == clns_pkg::KIND_INIT) ? clns_pkg::INIT_BYTES[byte_pos[3:2]]
                                                    : byte_ff;
      cur_rs    = (kind_ff == clns_pkg::KIND_INIT) ? 1'b0 : rs_ff;

      gen = '0;
      if (in_pulse_phase) begin
         gen.reg_select = rs_lvl_ff;
         gen.enable     = ~step_ff[0];
         gen.nibble     = nib_lvl_ff;
         gen.wait_ms    = step_ff[0] ? clns_pkg::WAIT_NONE : clns_pkg::WAIT_PULSE;
      end else if (in_reset_phase) begin
         gen.reg_select = 1'b0;
         if (reset_pos == 5'd0) begin
            gen.enable  = (kind_ff == clns_pkg::KIND_INIT) ? 1'b0 : en_lvl_ff;
            gen.nibble  = (kind_ff == clns_pkg::KIND_INIT) ? 4'h0 : nib_lvl_ff;
            gen.wait_ms = clns_pkg::WAIT_POWER_UP;
         end else begin
            gen.enable  = ~wake_pos[0];
            gen.nibble  = (wake_pos[2:1] == 2'd3) ? clns_pkg::NIBBLE_FOUR_BIT
                                                  : clns_pkg::NIBBLE_WAKE;
            if (!wake_pos[0]) begin
               gen.wait_ms = clns_pkg::WAIT_PULSE;
            end else if (wake_pos == 3'd1 || wake_pos == 3'd3) begin
               gen.wait_ms = clns_pkg::WAIT_WAKE;
            end else begin
               gen.wait_ms = clns_pkg::WAIT_NONE;
            end
         end
      end else begin
         gen.reg_select = cur_rs;
         gen.enable     = ~byte_pos[0];
         gen.nibble     = byte_pos[1] ? cur_byte[3:0] : cur_byte[7:4];
         gen.wait_ms    = byte_pos[0] ? clns_pkg::WAIT_NONE : clns_pkg::WAIT_PULSE;
      end

      case (kind_ff)
         clns_pkg::KIND_BYTE:  gen.last = (step_ff == clns_pkg::LAST_STEP_BYTE);
         clns_pkg::KIND_RESET: gen.last = (step_ff == clns_pkg::LAST_STEP_RESET);
         clns_pkg::KIND_INIT:  gen.last = (step_ff == clns_pkg::LAST_STEP_INIT);
         default:              gen.last = 1'b1;
      endcase
   end

   always_comb begin
      advance    = busy_ff && (!rsp_valid_ff || !rsp_stall);
      finishing  = advance && gen.last;
      req_stall  = busy_ff && !finishing;
      req_accept = req_valid && !req_stall;

      busy_in = busy_ff;
      kind_in = kind_ff;
      step_in = step_ff;
      byte_in = byte_ff;
      rs_in   = rs_ff;
      if (advance) begin
         step_in = step_ff + 5'd1;
         if (gen.last) begin
            busy_in = 1'b0;
         end
      end
      if (req_accept) begin
         busy_in = req_known;
         kind_in = req_kind;
         step_in = 5'd0;
         byte_in = req_byte;
         rs_in   = req_rs;
      end

      rs_lvl_in  = advance ? gen.reg_select : rs_lvl_ff;
      en_lvl_in  = advance ? gen.enable     : en_lvl_ff;
      nib_lvl_in = advance ? gen.nibble     : nib_lvl_ff;

      rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);
      rsp_data_in  = advance ? gen : rsp_data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         kind_ff      <= clns_pkg::KIND_BYTE;
         step_ff      <= 5'd0;
         rs_lvl_ff    <= 1'b0;
         en_lvl_ff    <= 1'b0;
         nib_lvl_ff   <= 4'h0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         kind_ff      <= kind_in;
         step_ff      <= step_in;
         rs_lvl_ff    <= rs_lvl_in;
         en_lvl_ff    <= en_lvl_in;
         nib_lvl_ff   <= nib_lvl_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff     <= byte_in;
      rs_ff       <= rs_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

### bench/tb_char_lcd_nibble_command_sequencer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Character LCD nibble command sequencer testbench
// Sends LCD requests through the request channel and checks every pin state
// that comes back against a run predicted inside the bench. The stimulus
// covers directed requests, unknown types, a long result hold-off and a
// weighted random mix, with random idle cycles on both sides.
// ----------------------------------------------------------------------------
module tb_char_lcd_nibble_command_sequencer_top;

   localparam int IDLE_MAX        = 18;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int DRAIN_CYCLES    = 60;

   localparam logic [3:0] REQ_FIRST_UNUSED = clns_pkg::REQ_WRITE_CHAR + 4'd1;
   localparam logic [3:0] REQ_LAST_UNUSED  = 4'hF;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_stall;
   clns_pkg::clns_req_type req_data;
   logic                   rsp_valid;
   logic                   rsp_stall;
   clns_pkg::clns_rsp_type rsp_data;

   clns_pkg::clns_rsp_type pin_state_q[$];
   logic                   lcd_rs;
   logic                   lcd_en;
   logic [3:0]             lcd_nib;

   int           fault_count = 0;
   int           send_idle_max = 0;
   int           rsp_idle_max = 0;
   logic         hold_off_req = 1'b0;

   char_lcd_nibble_command_sequencer_top u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("Regression FAIL");
      $finish;
   end

   function automatic clns_pkg::clns_req_type make_req(input logic [3:0] kind, input logic a,
                                                       input logic b, input logic c,
                                                       input logic [6:0] addr,
                                                       input logic [7:0] ch);
      clns_pkg::clns_req_type r;
      r.req_type    = kind;
      r.flag_a      = a;
      r.flag_b      = b;
      r.flag_c      = c;
      r.ram_address = addr;
      r.char_code   = ch;
      return r;
   endfunction

   function automatic logic [7:0] command_byte(input clns_pkg::clns_req_type r);
      case (r.req_type)
         clns_pkg::REQ_FUNCTION_SET:
            return clns_pkg::CMD_FUNCTION_SET | {3'b000, r.flag_a, r.flag_b, r.flag_c, 2'b00};
         clns_pkg::REQ_ENTRY_MODE:
            return clns_pkg::CMD_ENTRY_MODE | {6'b000000, r.flag_a, r.flag_b};
         clns_pkg::REQ_CLEAR:
            return clns_pkg::CMD_CLEAR;
         clns_pkg::REQ_DISPLAY_CTRL:
            return clns_pkg::CMD_DISPLAY_CTRL | {5'b00000, r.flag_a, r.flag_b, r.flag_c};
         clns_pkg::REQ_CURSOR_SHIFT:
            return clns_pkg::CMD_CURSOR_SHIFT | {5'b00000, r.flag_a, 2'b00};
         clns_pkg::REQ_DISPLAY_SHIFT:
            return clns_pkg::CMD_DISPLAY_SHIFT | {5'b00000, r.flag_a, 2'b00};
         clns_pkg::REQ_HOME:
            return clns_pkg::CMD_HOME;
         clns_pkg::REQ_CGRAM_ADDR:
            return clns_pkg::CMD_CGRAM_ADDR | {2'b00, r.ram_address[5:0]};
         clns_pkg::REQ_DDRAM_ADDR:
            return clns_pkg::CMD_DDRAM_ADDR | {1'b0, r.ram_address};
         clns_pkg::REQ_LINE_SELECT:
            return r.flag_a ? (clns_pkg::CMD_DDRAM_ADDR | clns_pkg::LINE_TWO_ADDR)
                            : clns_pkg::CMD_DDRAM_ADDR;
         default:
            return r.char_code;
      endcase
   endfunction

   function automatic void add_state(input logic rs, input logic en, input logic [3:0] nib,
                                     input logic [6:0] hold);
      clns_pkg::clns_rsp_type s;
      lcd_rs       = rs;
      lcd_en       = en;
      lcd_nib      = nib;
      s.reg_select = rs;
      s.enable     = en;
      s.nibble     = nib;
      s.wait_ms    = hold;
      s.last       = 1'b0;
      pin_state_q.push_back(s);
   endfunction

   function automatic void add_pulse(input logic rs, input logic [3:0] nib,
                                     input logic [6:0] low_hold);
      add_state(rs, 1'b1, nib, clns_pkg::WAIT_PULSE);
      add_state(rs, 1'b0, nib, low_hold);
   endfunction

   function automatic void add_byte(input logic rs, input logic [7:0] value);
      add_pulse(rs, value[7:4], clns_pkg::WAIT_NONE);
      add_pulse(rs, value[3:0], clns_pkg::WAIT_NONE);
   endfunction

   function automatic void add_wake_run();
      add_state(1'b0, lcd_en, lcd_nib, clns_pkg::WAIT_POWER_UP);
      add_pulse(1'b0, clns_pkg::NIBBLE_WAKE, clns_pkg::WAIT_WAKE);
      add_pulse(1'b0, clns_pkg::NIBBLE_WAKE, clns_pkg::WAIT_WAKE);
      add_pulse(1'b0, clns_pkg::NIBBLE_WAKE, clns_pkg::WAIT_NONE);
      add_pulse(1'b0, clns_pkg::NIBBLE_FOUR_BIT, clns_pkg::WAIT_NONE);
   endfunction

   function automatic void predict_pin_states(input clns_pkg::clns_req_type r);
      case (r.req_type)
         clns_pkg::REQ_INIT: begin
            add_pulse(lcd_rs, lcd_nib, clns_pkg::WAIT_NONE);
            lcd_rs  = 1'b0;
            lcd_en  = 1'b0;
            lcd_nib = 4'b0000;
            add_wake_run();
            add_byte(1'b0, command_byte(make_req(clns_pkg::REQ_FUNCTION_SET, 1'b0, 1'b1,
                                                 1'b0, '0, '0)));
            add_byte(1'b0, command_byte(make_req(clns_pkg::REQ_CLEAR, 1'b0, 1'b0,
                                                 1'b0, '0, '0)));
            add_byte(1'b0, command_byte(make_req(clns_pkg::REQ_DISPLAY_CTRL, 1'b1, 1'b1,
                                                 1'b1, '0, '0)));
            add_byte(1'b0, command_byte(make_req(clns_pkg::REQ_ENTRY_MODE, 1'b1, 1'b0,
                                                 1'b0, '0, '0)));
         end
         clns_pkg::REQ_RESET: add_wake_run();
         clns_pkg::REQ_FUNCTION_SET, clns_pkg::REQ_ENTRY_MODE, clns_pkg::REQ_CLEAR,
         clns_pkg::REQ_DISPLAY_CTRL, clns_pkg::REQ_CURSOR_SHIFT,
         clns_pkg::REQ_DISPLAY_SHIFT, clns_pkg::REQ_HOME, clns_pkg::REQ_CGRAM_ADDR,
         clns_pkg::REQ_DDRAM_ADDR, clns_pkg::REQ_LINE_SELECT:
            add_byte(1'b0, command_byte(r));
         clns_pkg::REQ_WRITE_CHAR: add_byte(1'b1, r.char_code);
         default: return;
      endcase
      pin_state_q[pin_state_q.size() - 1].last = 1'b1;
   endfunction

   function automatic clns_pkg::clns_req_type random_request();
      int         pick;
      logic [3:0] kind;
      pick = $urandom_range(0, 99);
      if (pick < 4)
         kind = clns_pkg::REQ_INIT;
      else if (pick < 9)
         kind = clns_pkg::REQ_RESET;
      else if (pick < 14)
         kind = 4'($urandom_range(REQ_FIRST_UNUSED, REQ_LAST_UNUSED));
      else
         kind = 4'($urandom_range(clns_pkg::REQ_FUNCTION_SET, clns_pkg::REQ_WRITE_CHAR));
      return make_req(kind, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)), 7'($urandom), 8'($urandom));
   endfunction

   task automatic send_request(input clns_pkg::clns_req_type item);
      int gap;
      gap = $urandom_range(0, send_idle_max);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
      predict_pin_states(item);
      @(negedge clock);
   endtask

   task automatic test_wake_runs();
      send_idle_max = IDLE_MAX;
      rsp_idle_max  = IDLE_MAX;
      send_request(make_req(clns_pkg::REQ_INIT, 1'b0, 1'b0, 1'b0, 7'h00, 8'h00));
      send_request(make_req(clns_pkg::REQ_WRITE_CHAR, 1'b1, 1'b1, 1'b1, 7'h7F, 8'hFF));
      send_request(make_req(clns_pkg::REQ_INIT, 1'b1, 1'b1, 1'b1, 7'h7F, 8'hFF));
      send_request(make_req(clns_pkg::REQ_WRITE_CHAR, 1'b0, 1'b0, 1'b0, 7'h00, 8'hA5));
      send_request(make_req(clns_pkg::REQ_RESET, 1'b1, 1'b1, 1'b1, 7'h7F, 8'hFF));
   endtask

   task automatic test_byte_requests();
      send_idle_max = 0;
      rsp_idle_max  = 0;
      send_request(make_req(clns_pkg::REQ_FUNCTION_SET, 1'b0, 1'b0, 1'b0, 7'h7F, 8'hFF));
      send_request(make_req(clns_pkg::REQ_FUNCTION_SET, 1'b1, 1'b1, 1'b1, 7'h00, 8'h00));
      send_request(make_req(clns_pkg::REQ_ENTRY_MODE, 1'b0, 1'b0, 1'b1, 7'h00, 8'h00));
      send_request(make_req(clns_pkg::REQ_ENTRY_MODE, 1'b1, 1'b1, 1'b0, 7'h7F, 8'hFF));
      send_request(make_req(clns_pkg::REQ_CLEAR, 1'b1, 1'b1, 1'b1, 7'h7F, 8'hFF));
      send_request(make_req(clns_pkg::REQ_DISPLAY_CTRL, 1'b0, 1'b0, 1'b0, 7'h00, 8'h00));
      send_request(make_req(clns_pkg::REQ_DISPLAY_CTRL, 1'b1, 1'b1, 1'b1, 7'h00, 8'h00));
      send_idle_max = IDLE_MAX;
      send_request(make_req(clns_pkg::REQ_CURSOR_SHIFT, 1'b0, 1'b1, 1'b1, 7'h00, 8'h00));
      send_request(make_req(clns_pkg::REQ_CURSOR_SHIFT, 1'b1, 1'b0, 1'b0, 7'h00, 8'h00));
      send_request(make_req(clns_pkg::REQ_DISPLAY_SHIFT, 1'b0, 1'b1, 1'b1, 7'h00, 8'h00));
      send_request(make_req(clns_pkg::REQ_DISPLAY_SHIFT, 1'b1, 1'b0, 1'b0, 7'h00, 8'h00));
      send_request(make_req(clns_pkg::REQ_HOME, 1'b0, 1'b0, 1'b0, 7'h00, 8'h00));
      rsp_idle_max = IDLE_MAX;
      send_request(make_req(clns_pkg::REQ_CGRAM_ADDR, 1'b0, 1'b0, 1'b0, 7'h7F, 8'h00));
      send_request(make_req(clns_pkg::REQ_CGRAM_ADDR, 1'b1, 1'b1, 1'b1, 7'h00, 8'hFF));
      send_request(make_req(clns_pkg::REQ_DDRAM_ADDR, 1'b0, 1'b0, 1'b0, 7'h7F, 8'h00));
      send_request(make_req(clns_pkg::REQ_DDRAM_ADDR, 1'b1, 1'b1, 1'b1, 7'h00, 8'hFF));
      send_request(make_req(clns_pkg::REQ_LINE_SELECT, 1'b0, 1'b1, 1'b1, 7'h7F, 8'hFF));
      send_request(make_req(clns_pkg::REQ_LINE_SELECT, 1'b1, 1'b0, 1'b0, 7'h00, 8'h00));
      send_request(make_req(clns_pkg::REQ_WRITE_CHAR, 1'b0, 1'b0, 1'b0, 7'h00, 8'h00));
   endtask

   task automatic test_unknown_types();
      logic [3:0] kind;
      send_idle_max = 0;
      rsp_idle_max  = IDLE_MAX;
      for (kind = REQ_FIRST_UNUSED; kind != 4'd0; kind++) begin
         send_request(make_req(kind, 1'b1, 1'b1, 1'b1, 7'h7F, 8'hFF));
         send_request(make_req(clns_pkg::REQ_WRITE_CHAR, 1'b0, 1'b0, 1'b0, 7'h00,
                               8'({kind, kind})));
      end
   endtask

   task automatic test_backpressure();
      int n;
      send_idle_max = 0;
      rsp_idle_max  = 0;
      hold_off_req  = 1'b1;
      for (n = 0; n < 30; n++)
         send_request(random_request());
   endtask

   task automatic test_random_mix();
      int chunk;
      int n;
      int mode;
      for (chunk = 0; chunk < 8; chunk++) begin
         mode          = (chunk == 0) ? 0 : $urandom_range(0, 3);
         send_idle_max = mode[0] ? IDLE_MAX : 0;
         rsp_idle_max  = mode[1] ? IDLE_MAX : 0;
         for (n = 0; n < 40; n++)
            send_request(random_request());
      end
   endtask

   initial begin : result_receiver
      int stall_left;
      int hold_left;
      stall_left = 0;
      hold_left  = 0;
      rsp_stall  = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall)
            stall_left = $urandom_range(0, rsp_idle_max);
         @(negedge clock);
         if (hold_off_req) begin
            hold_left    = HOLD_OFF_CYCLES;
            hold_off_req = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin : pin_state_check
      clns_pkg::clns_rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pin_state_q.size() == 0) begin
            $error("pin state %p arrived with none expected", rsp_data);
            fault_count++;
         end else begin
            want = pin_state_q.pop_front();
            if (rsp_data.reg_select !== want.reg_select) begin
               $error("reg_select expected %0d actual %0d", want.reg_select,
                      rsp_data.reg_select);
               fault_count++;
            end
            if (rsp_data.enable !== want.enable) begin
               $error("enable expected %0d actual %0d", want.enable, rsp_data.enable);
               fault_count++;
            end
            if (rsp_data.nibble !== want.nibble) begin
               $error("nibble expected %0h actual %0h", want.nibble, rsp_data.nibble);
               fault_count++;
            end
            if (rsp_data.wait_ms !== want.wait_ms) begin
               $error("wait_ms expected %0d actual %0d", want.wait_ms, rsp_data.wait_ms);
               fault_count++;
            end
            if (rsp_data.last !== want.last) begin
               $error("last expected %0d actual %0d", want.last, rsp_data.last);
               fault_count++;
            end
         end
      end
   end

   initial begin
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      lcd_rs    = 1'b0;
      lcd_en    = 1'b0;
      lcd_nib   = 4'b0000;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_wake_runs();
      test_byte_requests();
      test_unknown_types();
      test_backpressure();
      test_random_mix();
      req_valid <= 1'b0;

      while (pin_state_q.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (pin_state_q.size() != 0) begin
         $error("%0d expected pin states never arrived", pin_state_q.size());
         fault_count++;
      end
      if (fault_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
